[hdl/esp_pkg.sv]
package esp_pkg;

  typedef enum logic [1:0] {
    ACT_ENCODER = 2'd0,
    ACT_BYTE    = 2'd1,
    ACT_STOP    = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    DIR_STOP    = 2'd0,
    DIR_FORWARD = 2'd1,
    DIR_REVERSE = 2'd2
  } dir_e;

  typedef enum logic [1:0] {
    REG_DRIVE_DUTY = 2'd0,
    REG_DEAD_BAND  = 2'd1,
    REG_SCALE      = 2'd2
  } cfg_reg_e;

  localparam logic [1:0] AB_A_ONLY = 2'd1;
  localparam logic [1:0] AB_B_ONLY = 2'd2;
  localparam logic [1:0] AB_BOTH   = 2'd3;

  localparam logic [1:0] MESSAGE_BYTES = 2'd2;
  localparam logic [1:0] HELD_OVERRUN  = MESSAGE_BYTES + 2'd1;

  localparam logic [6:0] DRIVE_DUTY_RST = 7'd5;
  localparam logic [7:0] DEAD_BAND_RST  = 8'd2;
  localparam logic [7:0] SCALE_RST      = 8'd25;

  // x / 10 == (x * RECIP_10) >> RECIP_SHIFT for any x below 2**24
  localparam int unsigned RECIP_SHIFT = 27;
  localparam logic [23:0] RECIP_10    = 24'd13421773;

  localparam logic [15:0] TARGET_MAX = 16'h7FFF;

  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 48;

endpackage

[hdl/encoder_servo_position_controller_unit.sv]
// Quadrature encoder bang-bang position servo. Each input request is one event
// (encoder sample, bus byte, bus stop) and yields exactly one drive decision
// with the position and target after that event. The block takes one request
// per clock while the output is not stalled, and returns its result through
// registered stages in order: the encoder count and byte buffer update, the
// angle times scale product, the divide by ten as a reciprocal multiply with
// saturation, and the deadband compare. A stalled result holds the whole pipeline,
// so input ready follows output ready whenever a result is waiting. Configuration
// writes are taken in any cycle.
module encoder_servo_position_controller_unit
  import esp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // encoder_ab[1:0], rx_byte[9:2]
  input  logic [1:0]            s_axis_tuser,   // action[1:0]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // direction[1:0], duty[8:2],
                                                // position[24:9], target[40:25]
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [7:0]            cfg_data_i
);

  logic [6:0] duty_cfg_q;
  logic [7:0] band_cfg_q;
  logic [7:0] scale_cfg_q;

  logic       advance;
  logic       accept;
  action_e    action;
  logic [1:0] enc_ab;
  logic [7:0] rx_byte;

  logic [1:0]  last_ab_q, last_ab_d;
  logic [15:0] pos_q, pos_d;
  logic [1:0]  held_q, held_d;
  logic [7:0]  store_q [2];
  logic        store_we;
  logic        load_d;

  logic        v1_q, load1_q;
  logic [15:0] pos1_q, angle1_q;
  logic        v2_q, load2_q;
  logic [15:0] pos2_q;
  logic [23:0] prod2_q;
  logic        v3_q;
  logic [15:0] pos3_q, tgt3_q;
  logic [15:0] target_q;

  logic [47:0] recip_prod;
  logic [20:0] quot;
  logic [15:0] tgt_sat, tgt_new;

  logic signed [17:0] pos_x, tgt_x, band_x;
  dir_e        dir_d;
  logic [6:0]  duty_d;

  logic        out_valid_q;
  dir_e        dir_q;
  logic [6:0]  duty_q;
  logic [15:0] opos_q, otgt_q;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = advance;
  assign accept        = s_axis_tvalid && advance;
  assign action        = action_e'(s_axis_tuser);
  assign enc_ab        = s_axis_tdata[1:0];
  assign rx_byte       = s_axis_tdata[9:2];
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_cfg_q  <= DRIVE_DUTY_RST;
      band_cfg_q  <= DEAD_BAND_RST;
      scale_cfg_q <= SCALE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_DRIVE_DUTY: duty_cfg_q  <= cfg_data_i[6:0];
        REG_DEAD_BAND:  band_cfg_q  <= cfg_data_i;
        REG_SCALE:      scale_cfg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    last_ab_d = last_ab_q;
    pos_d     = pos_q;
    held_d    = held_q;
    store_we  = 1'b0;
    load_d    = 1'b0;
    case (action)
      ACT_ENCODER: begin
        if (enc_ab != last_ab_q) begin
          if (last_ab_q == AB_A_ONLY && enc_ab == AB_BOTH) begin
            pos_d = pos_q + 16'd1;
          end else if (last_ab_q == AB_B_ONLY && enc_ab == AB_BOTH) begin
            pos_d = pos_q - 16'd1;
          end
          last_ab_d = enc_ab;
        end
      end
      ACT_BYTE: begin
        if (held_q < MESSAGE_BYTES) begin
          store_we = accept;
          held_d   = held_q + 2'd1;
        end else begin
          held_d = HELD_OVERRUN;
        end
      end
      ACT_STOP: begin
        load_d = (held_q == MESSAGE_BYTES);
        held_d = 2'd0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_ab_q <= 2'd0;
      pos_q     <= 16'd0;
      held_q    <= 2'd0;
    end else if (accept) begin
      last_ab_q <= last_ab_d;
      pos_q     <= pos_d;
      held_q    <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[held_q[0]] <= rx_byte;
    end
  end

  // stage 1: count and byte buffer updated
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (advance) begin
      v1_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      pos1_q   <= pos_d;
      load1_q  <= load_d;
      angle1_q <= {store_q[0], store_q[1]};
    end
  end

  // stage 2: angle times scale
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (advance) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      pos2_q  <= pos1_q;
      load2_q <= load1_q;
      prod2_q <= 24'(angle1_q) * 24'(scale_cfg_q);
    end
  end

  // stage 3: divide by ten, saturate, update target
  assign recip_prod = 48'(prod2_q) * 48'(RECIP_10);
  assign quot       = recip_prod[RECIP_SHIFT +: 21];
  assign tgt_sat    = (|quot[20:15]) ? TARGET_MAX : quot[15:0];
  assign tgt_new    = load2_q ? tgt_sat : target_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q     <= 1'b0;
      target_q <= 16'd0;
    end else if (advance) begin
      v3_q <= v2_q;
      if (v2_q) begin
        target_q <= tgt_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      pos3_q <= pos2_q;
      tgt3_q <= tgt_new;
    end
  end

  // stage 4: deadband compare
  assign pos_x  = 18'(signed'(pos3_q));
  assign tgt_x  = 18'(signed'(tgt3_q));
  assign band_x = signed'({10'd0, band_cfg_q});

  always_comb begin
    dir_d  = DIR_STOP;
    duty_d = 7'd0;
    if (pos_x < tgt_x - band_x) begin
      dir_d  = DIR_FORWARD;
      duty_d = duty_cfg_q;
    end else if (pos_x > tgt_x + band_x) begin
      dir_d  = DIR_REVERSE;
      duty_d = duty_cfg_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      dir_q  <= dir_d;
      duty_q <= duty_d;
      opos_q <= pos3_q;
      otgt_q <= tgt3_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, otgt_q, opos_q, duty_q, dir_q};

endmodule

[hdl/esp_checker.sv]
module esp_checker
  import esp_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic        out_acc;
  logic [1:0]  dir;
  logic [6:0]  duty;
  logic [15:0] pos, tgt, prev_pos_q, step;
  logic        seen_q;

  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign dir     = m_axis_tdata[1:0];
  assign duty    = m_axis_tdata[8:2];
  assign pos     = m_axis_tdata[24:9];
  assign tgt     = m_axis_tdata[40:25];
  assign step    = pos - prev_pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= 1'b0;
      prev_pos_q <= 16'd0;
    end else if (out_acc) begin
      seen_q     <= 1'b1;
      prev_pos_q <= pos;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_stop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && dir == DIR_STOP |-> duty == 7'd0)
    else $error("duty nonzero while stopped");

  a_dir_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (dir == DIR_STOP) ||
      (dir == DIR_FORWARD && $signed(pos) < $signed(tgt)) ||
      (dir == DIR_REVERSE && $signed(pos) > $signed(tgt)))
    else $error("drive direction disagrees with position error");

  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && seen_q |-> step == 16'd0 || step == 16'd1 || step == 16'hFFFF)
    else $error("position moved more than one count per request");

endmodule

bind encoder_servo_position_controller_unit esp_checker u_esp_checker (.*);

[tb/sv/encoder_servo_position_controller_unit_tb.sv]
module encoder_servo_position_controller_unit_tb
  import esp_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES = 300;
  localparam int MAX_SHOWN   = 10;

  typedef struct packed {
    dir_e        dir;
    logic [6:0]  duty;
    logic [15:0] pos;
    logic [15:0] tgt;
  } drive_t;

  typedef struct {
    action_e    act;
    logic [1:0] ab;
    logic [7:0] rx;
    bit         pinned;
    drive_t     want;
  } step_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [1:0]            s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [1:0]            cfg_index_i;
  logic [7:0]            cfg_data_i;

  logic [6:0]  duty_cfg  = DRIVE_DUTY_RST;
  logic [7:0]  band_cfg  = DEAD_BAND_RST;
  logic [7:0]  scale_cfg = SCALE_RST;
  logic [1:0]  enc_lines = 2'd0;
  logic [15:0] pos_cnt   = 16'd0;
  logic [15:0] tgt_cnt   = 16'd0;
  logic [7:0]  rx_bytes [2];
  logic [1:0]  rx_held   = 2'd0;

  drive_t drive_q [$];
  int     mismatches = 0;
  int     feed_idle_pct;
  int     drain_idle_pct;
  bit     hold_req;
  bit     pin_on;
  drive_t pin_want;

  step_t directed_steps [23];

  encoder_servo_position_controller_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    #30_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic drive_t servo_step(action_e act, logic [1:0] ab, logic [7:0] rx);
    drive_t      r;
    int          p;
    int          tg;
    int          bd;
    logic [23:0] prod;
    int unsigned q;
    case (act)
      ACT_ENCODER: begin
        if (ab != enc_lines) begin
          if (enc_lines == AB_A_ONLY && ab == AB_BOTH) pos_cnt = pos_cnt + 16'd1;
          else if (enc_lines == AB_B_ONLY && ab == AB_BOTH) pos_cnt = pos_cnt - 16'd1;
          enc_lines = ab;
        end
      end
      ACT_BYTE: begin
        if (rx_held < MESSAGE_BYTES) begin
          rx_bytes[rx_held[0]] = rx;
          rx_held = rx_held + 2'd1;
        end else begin
          rx_held = HELD_OVERRUN;
        end
      end
      ACT_STOP: begin
        if (rx_held == MESSAGE_BYTES) begin
          prod = 24'({rx_bytes[0], rx_bytes[1]}) * 24'(scale_cfg);
          q = {8'd0, prod} / 32'd10;
          if (q > 32'(TARGET_MAX)) q = 32'(TARGET_MAX);
          tgt_cnt = q[15:0];
        end
        rx_held = 2'd0;
      end
      default: ;
    endcase
    p  = int'($signed(pos_cnt));
    tg = int'($signed(tgt_cnt));
    bd = int'(band_cfg);
    r.pos  = pos_cnt;
    r.tgt  = tgt_cnt;
    r.dir  = DIR_STOP;
    r.duty = 7'd0;
    if (p < tg - bd) begin
      r.dir  = DIR_FORWARD;
      r.duty = duty_cfg;
    end else if (p > tg + bd) begin
      r.dir  = DIR_REVERSE;
      r.duty = duty_cfg;
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    drive_t got;
    drive_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_DRIVE_DUTY: duty_cfg  = cfg_data_i[6:0];
          REG_DEAD_BAND:  band_cfg  = cfg_data_i;
          REG_SCALE:      scale_cfg = cfg_data_i;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{dir_e'(m_axis_tdata[1:0]), m_axis_tdata[8:2], m_axis_tdata[24:9],
                m_axis_tdata[40:25]};
        if (drive_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("unexpected drive result: dir %0d duty %0d pos %0d tgt %0d",
                     got.dir, got.duty, $signed(got.pos), $signed(got.tgt));
        end else begin
          want = drive_q.pop_front();
          if (got.dir != want.dir || got.duty != want.duty || got.pos != want.pos ||
              got.tgt != want.tgt) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
              $display("mismatch (dir duty pos tgt): expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                       want.dir, want.duty, $signed(want.pos), $signed(want.tgt),
                       got.dir, got.duty, $signed(got.pos), $signed(got.tgt));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = servo_step(action_e'(s_axis_tuser), s_axis_tdata[1:0], s_axis_tdata[9:2]);
        if (pin_on) want = pin_want;
        drive_q.push_back(want);
      end
    end
  end

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      m_axis_tready <= ($urandom_range(99) >= drain_idle_pct);
    end
  end

  task automatic offer_event(action_e act, logic [1:0] ab, logic [7:0] rx);
    while ($urandom_range(99) < feed_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {6'd0, rx, ab};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (drive_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [7:0] value);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_all(logic [7:0] duty, logic [7:0] band, logic [7:0] scale);
    write_reg(REG_DRIVE_DUTY, duty);
    write_reg(REG_DEAD_BAND, band);
    write_reg(REG_SCALE, scale);
  endtask

  task automatic random_events(int count);
    int         done;
    int         len;
    int         kind;
    bit         up;
    logic [1:0] lines;
    logic [7:0] hi;
    logic [7:0] lo;
    done = 0;
    while (done < count) begin
      kind = $urandom_range(99);
      if (kind < 55) begin
        len = $urandom_range(12, 1);
        up  = 1'($urandom_range(1));
        repeat (len) begin
          case (enc_lines)
            2'd0:      lines = up ? AB_A_ONLY : AB_B_ONLY;
            AB_A_ONLY: lines = up ? AB_BOTH : 2'd0;
            AB_BOTH:   lines = up ? AB_B_ONLY : AB_A_ONLY;
            default:   lines = up ? 2'd0 : AB_BOTH;
          endcase
          offer_event(ACT_ENCODER, lines, 8'($urandom_range(255)));
        end
        done += len;
      end else if (kind < 75) begin
        if ($urandom_range(1)) begin
          hi = 8'd0;
          lo = 8'($urandom_range(8));
        end else begin
          hi = 8'($urandom_range(255));
          lo = 8'($urandom_range(255));
        end
        offer_event(ACT_BYTE, 2'($urandom_range(3)), hi);
        offer_event(ACT_BYTE, 2'($urandom_range(3)), lo);
        offer_event(ACT_STOP, 2'($urandom_range(3)), 8'($urandom_range(255)));
        done += 3;
      end else if (kind < 85) begin
        len = $urandom_range(4);
        if (len >= 2) len++;
        repeat (len) offer_event(ACT_BYTE, 2'($urandom_range(3)), 8'($urandom_range(255)));
        if ($urandom_range(3) != 0) begin
          offer_event(ACT_STOP, 2'($urandom_range(3)), 8'($urandom_range(255)));
          done++;
        end
        done += len;
      end else if (kind < 93) begin
        offer_event(ACT_ENCODER, 2'($urandom_range(3)), 8'($urandom_range(255)));
        done++;
      end else begin
        offer_event(ACT_NONE, 2'($urandom_range(3)), 8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    directed_steps = '{
      '{ACT_ENCODER, 2'd0,      8'h00, 1'b1, '{DIR_STOP, 7'd0, 16'h0000, 16'h0000}},
      '{ACT_ENCODER, AB_A_ONLY, 8'hFF, 1'b1, '{DIR_STOP, 7'd0, 16'h0000, 16'h0000}},
      '{ACT_ENCODER, AB_BOTH,   8'h00, 1'b1, '{DIR_STOP, 7'd0, 16'h0001, 16'h0000}},
      '{ACT_ENCODER, AB_B_ONLY, 8'h00, 1'b0, '{DIR_STOP, 7'd0, 16'h0000, 16'h0000}},
      '{ACT_ENCODER, AB_BOTH,   8'h00, 1'b0, '{DIR_STOP, 7'd0, 16'h0000, 16'h0000}},
      '{ACT_ENCODER, AB_A_ONLY, 8'h00, 1'b0, '{DIR_STOP, 7'd0, 16'h0000, 16'h0000}},
      '{ACT_ENCODER, 2'd0,      8'h00, 1'b0, '{DIR_STOP, 7'd0, 16'h0000, 16'h0000}},
      '{ACT_ENCODER, AB_B_ONLY, 8'h00, 1'b0, '{DIR_STOP, 7'd0, 16'h0000, 16'h0000}},
      '{ACT_ENCODER, AB_BOTH,   8'h00, 1'b1, '{DIR_STOP, 7'd0, 16'hFFFF, 16'h0000}},
      '{ACT_BYTE,    2'd0,      8'hFF, 1'b0, '{DIR_STOP, 7'd0, 16'h0000, 16'h0000}},
      '{ACT_BYTE,    AB_BOTH,   8'hFF, 1'b0, '{DIR_STOP, 7'd0, 16'h0000, 16'h0000}},
      '{ACT_STOP,    2'd0,      8'h00, 1'b1, '{DIR_FORWARD, 7'd5, 16'hFFFF, 16'h7FFF}},
      '{ACT_NONE,    AB_A_ONLY, 8'hFF, 1'b1, '{DIR_FORWARD, 7'd5, 16'hFFFF, 16'h7FFF}},
      '{ACT_BYTE,    2'd0,      8'h00, 1'b0, '{DIR_STOP, 7'd0, 16'h0000, 16'h0000}},
      '{ACT_BYTE,    2'd0,      8'h05, 1'b0, '{DIR_STOP, 7'd0, 16'h0000, 16'h0000}},
      '{ACT_BYTE,    2'd0,      8'hAA, 1'b0, '{DIR_STOP, 7'd0, 16'h0000, 16'h0000}},
      '{ACT_STOP,    2'd0,      8'h00, 1'b1, '{DIR_FORWARD, 7'd5, 16'hFFFF, 16'h7FFF}},
      '{ACT_BYTE,    2'd0,      8'h01, 1'b0, '{DIR_STOP, 7'd0, 16'h0000, 16'h0000}},
      '{ACT_STOP,    2'd0,      8'h00, 1'b1, '{DIR_FORWARD, 7'd5, 16'hFFFF, 16'h7FFF}},
      '{ACT_STOP,    2'd0,      8'h00, 1'b1, '{DIR_FORWARD, 7'd5, 16'hFFFF, 16'h7FFF}},
      '{ACT_BYTE,    2'd0,      8'h00, 1'b0, '{DIR_STOP, 7'd0, 16'h0000, 16'h0000}},
      '{ACT_BYTE,    2'd0,      8'h00, 1'b0, '{DIR_STOP, 7'd0, 16'h0000, 16'h0000}},
      '{ACT_STOP,    2'd0,      8'h00, 1'b1, '{DIR_STOP, 7'd0, 16'hFFFF, 16'h0000}}
    };
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tuser   = ACT_ENCODER;
    s_axis_tdata   = '0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = REG_DRIVE_DUTY;
    cfg_data_i     = 8'd0;
    feed_idle_pct  = 35;
    drain_idle_pct = 82;
    hold_req       = 1'b0;
    pin_on         = 1'b0;
    pin_want       = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_steps[i]) begin
      pin_on   = directed_steps[i].pinned;
      pin_want = directed_steps[i].want;
      offer_event(directed_steps[i].act, directed_steps[i].ab, directed_steps[i].rx);
      pin_on   = 1'b0;
    end

    write_all(8'd99, 8'd0, 8'd255);
    random_events(200);
    write_all(8'd0, 8'd255, 8'd0);
    random_events(200);

    feed_idle_pct  = 82;
    drain_idle_pct = 35;
    write_all(8'($urandom_range(99)), 8'($urandom_range(255)), 8'($urandom_range(255)));
    random_events(200);
    write_all(8'(DRIVE_DUTY_RST), DEAD_BAND_RST, SCALE_RST);
    random_events(200);

    feed_idle_pct  = 0;
    drain_idle_pct = 0;
    write_all(8'($urandom_range(99)), 8'($urandom_range(7)), 8'($urandom_range(255)));
    hold_req = 1'b1;
    random_events(400);

    // bring the count to -4 or below, then walk it up through zero to 4
    write_all(8'd42, 8'd3, 8'd255);
    while ($signed(pos_cnt) > -16'sd4) begin
      offer_event(ACT_ENCODER, AB_B_ONLY, 8'($urandom_range(255)));
      offer_event(ACT_ENCODER, AB_BOTH, 8'($urandom_range(255)));
    end
    while ($signed(pos_cnt) < 16'sd4) begin
      offer_event(ACT_ENCODER, AB_A_ONLY, 8'($urandom_range(255)));
      offer_event(ACT_ENCODER, AB_BOTH, 8'($urandom_range(255)));
    end

    s_axis_tvalid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

[filelist.f]
hdl/esp_pkg.sv
hdl/encoder_servo_position_controller_unit.sv
hdl/esp_checker.sv
tb/sv/encoder_servo_position_controller_unit_tb.sv
